### hw/rtl/oaht_pkg.sv
// shared types and constants for the open-addressing hash table
package oaht_pkg;

	localparam int KEY_W   = 34;
	localparam int SLOT_W  = 4;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int DIGIT_W = 4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd2;

	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FOUND    = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISSING  = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [KEY_W-1:0]  key;
		logic [MODE_W-1:0] probe_mode;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic probe_start;
		logic probe_run;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic hash_busy;
		logic fin;
	} dp_status_t;

endpackage

### hw/rtl/oaht_ram.sv
// generic simple dual-port ram with registered read
module oaht_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/oaht_mod.sv
// key modulo table size, four key bits per cycle
module oaht_mod import oaht_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KEY_W-1:0]              key,
	output logic                          busy,
	output logic [$clog2(TABLE_SIZE)-1:0] rem
);

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W  = DIGITS * DIGIT_W;
	localparam int DCNT_W = $clog2(DIGITS + 1);
	localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_SIZE);

	logic [PAD_W-1:0]  shift_q;
	logic [IDX_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;

	// remainder stays below TABLE_SIZE, so each bit needs one compare and subtract
	function automatic logic [IDX_W-1:0] digit_step(input logic [IDX_W-1:0] r,
			input logic [DIGIT_W-1:0] d);
		logic [IDX_W:0]   t;
		logic [IDX_W-1:0] acc;
		acc = r;
		for (int b = DIGIT_W - 1; b >= 0; b--) begin
			t = {acc, d[b]};
			if (t >= N_EXT) begin
				t = t - N_EXT;
			end
			acc = t[IDX_W-1:0];
		end
		return acc;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DIGITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= PAD_W'(key);
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << DIGIT_W;
			rem_q   <= digit_step(rem_q, shift_q[PAD_W-1 -: DIGIT_W]);
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

### hw/rtl/oaht_dp.sv
// datapath: item registers, hash unit, probe address generator, slot ram and result register
module oaht_dp import oaht_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  ctrl_cmd_t  cmd,
	output dp_status_t st,
	output out_item_t  out_data
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int ENT_W = KEY_W + 1;
	localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [IDX_W-1:0] TWO_MOD  = IDX_W'(2 % TABLE_SIZE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE);

	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  home;
	logic              hash_busy;

	logic [IDX_W-1:0] addr_q, sq_q, odd_q;
	logic [CNT_W-1:0] pcnt_q;
	logic             issued_last_q;
	logic [IDX_W-1:0] clr_q;

	logic [IDX_W-1:0] addr_s1;
	logic             last_s1;
	logic             rd_vld_s1;

	logic             issue, last_issue;
	logic [IDX_W-1:0] sq_nxt, odd_nxt, addr_nxt;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [ENT_W-1:0] wdata, rdata;
	logic             ent_vld, hit;
	logic [KEY_W-1:0] ent_key;
	logic [IDX_W+SLOT_W-1:0] slot_ext;
	out_item_t        out_q;

	function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= N_EXT) begin
			t = t - N_EXT;
		end
		return t[IDX_W-1:0];
	endfunction

	oaht_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.capture),
		.key    (in_data.key),
		.busy   (hash_busy),
		.rem    (home)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_data.cmd;
			key_q  <= in_data.key;
			mode_q <= in_data.probe_mode;
		end
	end

	// probe sequence: insert follows the collision rule from home, search checks
	// home and then every slot from zero upward
	always_comb begin
		issue   = cmd.probe_run && !issued_last_q;
		sq_nxt  = add_mod(sq_q, odd_q);
		odd_nxt = add_mod(odd_q, TWO_MOD);
		if (cmd_q == CMD_SEARCH) begin
			last_issue = (pcnt_q == CNT_FULL);
			addr_nxt   = (pcnt_q == '0) ? '0 : addr_q + 1'b1;
		end else begin
			unique case (mode_q)
				MODE_LINEAR: begin
					last_issue = (addr_q == LAST_IDX);
					addr_nxt   = addr_q + 1'b1;
				end
				MODE_QUAD: begin
					last_issue = (pcnt_q == CNT_LAST);
					addr_nxt   = add_mod(home, sq_nxt);
				end
				default: begin
					last_issue = 1'b1;
					addr_nxt   = addr_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_start) begin
			addr_q <= home;
			pcnt_q <= '0;
			sq_q   <= '0;
			odd_q  <= IDX_W'(1);
		end else if (issue) begin
			addr_q <= addr_nxt;
			pcnt_q <= pcnt_q + 1'b1;
			sq_q   <= sq_nxt;
			odd_q  <= odd_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_last_q <= 1'b0;
			rd_vld_s1     <= 1'b0;
			clr_q         <= '0;
		end else begin
			if (cmd.probe_start) begin
				issued_last_q <= 1'b0;
			end else if (issue && last_issue) begin
				issued_last_q <= 1'b1;
			end
			rd_vld_s1 <= issue;
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		last_s1 <= last_issue;
	end

	oaht_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_SIZE)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign ent_vld = rdata[KEY_W];
	assign ent_key = rdata[KEY_W-1:0];
	assign hit     = (cmd_q == CMD_INSERT) ? !ent_vld : (ent_vld && (ent_key == key_q));

	assign we    = cmd.clear || (cmd.finish && (cmd_q == CMD_INSERT) && hit);
	assign waddr = cmd.clear ? clr_q : addr_s1;
	assign wdata = cmd.clear ? '0 : {1'b1, key_q};

	assign slot_ext = {{SLOT_W{1'b0}}, addr_s1};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd_q == CMD_INSERT) begin
				out_q.status <= hit ? ST_INSERTED : ST_REJECTED;
			end else begin
				out_q.status <= hit ? ST_FOUND : ST_MISSING;
			end
			out_q.slot <= hit ? slot_ext[SLOT_W-1:0] : '0;
		end
	end

	assign out_data      = out_q;
	assign st.clear_last = (clr_q == LAST_IDX);
	assign st.hash_busy  = hash_busy;
	assign st.fin        = rd_vld_s1 && (hit || last_s1);

	a_wr_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		we && !cmd.clear |-> (cmd_q == CMD_INSERT) && !ent_vld)
		else $error("slot write on an occupied slot");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ({1'b0, addr_s1} < N_EXT))
		else $error("probe address beyond table");

endmodule

### hw/rtl/oaht_ctrl.sv
// controller state machine: clearing pass, hashing, probing, result handoff
module oaht_ctrl import oaht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_HASH  = 4'b0100,
		S_PROBE = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_HASH;
				end
			end
			S_HASH: begin
				// hold off probing until the hash is done and the result register is free
				if (!st.hash_busy && !out_valid_q) begin
					cmd.probe_start = 1'b1;
					state_nxt       = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe_run = 1'b1;
				if (st.fin) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q)
		else $error("result produced while output register full");

	a_finish_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE) && out_valid_q)
		else $error("finish did not hand off the result");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_PROBE)
		else $error("result raised outside probing");

endmodule

### hw/rtl/open_addressing_hash_table.sv
// top level of the open-addressing hash table with linear and quadratic probing
// a transaction passes capture, key reduction modulo TABLE_SIZE, probe start once the
// result register is free, one ram read for each slot probed (1 to TABLE_SIZE for insert,
// 1 to TABLE_SIZE + 1 for search) and the result register, which raises out_valid
// in_ready is high only when idle, so no new transaction is taken until the last finishes
// after reset a clearing pass empties every slot with in_ready low
module open_addressing_hash_table import oaht_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	oaht_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_data)
	);

endmodule
